// File: rtl/core/caseless_prefix_substring_search_top_defines.svh
// Assertion macros shared by the caseless substring search RTL.
// Standalone header; included by modules that carry assertions.
`ifndef CASELESS_PREFIX_SUBSTRING_SEARCH_TOP_DEFINES_SVH
`define CASELESS_PREFIX_SUBSTRING_SEARCH_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/cps_pkg.sv
// Package for the caseless substring search: widths, register codes, case fold.
// No dependencies.
`timescale 1ns / 1ps

package cps_pkg;

    localparam int BYTE_W          = 8;
    localparam int CFG_W           = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int LEN_W           = 5;
    localparam int POS_W           = 32;
    localparam int PAT_IDX_W       = 4;   // 16 bytes across the two pattern words
    localparam int MAX_PATTERN_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 2'd3;

    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'd32;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

// File: rtl/core/cps_cell.sv
// One window cell: holds a folded byte and its valid bit, passes them on,
// and compares the byte it is about to take against its pattern byte.
// Depends on cps_pkg.
`timescale 1ns / 1ps

module cps_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      shift_en,
    input  logic                      clear,
    input  logic [cps_pkg::BYTE_W-1:0] byte_in,
    input  logic                      valid_in,
    input  logic [cps_pkg::BYTE_W-1:0] pat_byte,
    input  logic                      pat_use,
    output logic [cps_pkg::BYTE_W-1:0] byte_out,
    output logic                      valid_out,
    output logic                      hit
);
    import cps_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic              valid_reg;
    logic              valid_next;

    // hit looks at the value entering the cell, i.e. the window after the shift
    assign hit = !pat_use || (valid_in && (byte_in == pat_byte));

    always_comb begin
        valid_next = valid_reg;
        if (clear) begin
            valid_next = 1'b0;
        end else if (shift_en) begin
            valid_next = valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

// File: rtl/core/caseless_prefix_substring_search_top.sv
// Caseless substring search over the leading bytes of a buffer. Takes one byte
// per clock with no bubbles unless the output stalls: a row of MAX_PATTERN
// cells shifts the case-folded bytes and compares the whole window in the cycle
// a byte is accepted; the sticky found flag goes to the output word registered.
// Words past look_limit still produce results but do not enter the window.
// The word with tlast closes the buffer and clears window, position and flag.
// Configuration writes take effect for the next accepted word.
`timescale 1ns / 1ps

`include "caseless_prefix_substring_search_top_defines.svh"

module caseless_prefix_substring_search_top #(
    parameter int MAX_PATTERN = cps_pkg::MAX_PATTERN_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [cps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cps_pkg::CFG_W-1:0]     cfg_data,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] data_byte
    input  logic                         s_tlast,   // last_byte
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // [0] found, [7:1] zero
    output logic                         m_tlast    // buffer_done
);
    import cps_pkg::*;

    // configuration registers
    logic [CFG_W-1:0] pat_low_reg;
    logic [CFG_W-1:0] pat_high_reg;
    logic [LEN_W-1:0] pat_len_reg;
    logic [POS_W-1:0] limit_reg;

    // stream state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             seen_reg, seen_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic             found_reg;
    logic             last_reg;

    logic                 s_acc;
    logic                 in_lim;
    logic [LEN_W-1:0]     len_eff;
    logic [2*CFG_W-1:0]   pat_all;
    logic                 found_now;

    logic [BYTE_W-1:0]      byte_chain  [MAX_PATTERN+1];
    logic [MAX_PATTERN:0]   valid_chain;
    logic [BYTE_W-1:0]      cell_pat    [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_use;
    logic [MAX_PATTERN-1:0] cell_hit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
            limit_reg    <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PAT_LOW:  pat_low_reg  <= cfg_data;
                REG_PAT_HIGH: pat_high_reg <= cfg_data;
                REG_PAT_LEN:  pat_len_reg  <= cfg_data[LEN_W-1:0];
                REG_LIMIT:    limit_reg    <= cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    assign len_eff = (pat_len_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_reg;
    assign pat_all = {pat_high_reg, pat_low_reg};

    // cell k (newest byte at cell 0) checks pattern byte len-1-k
    always_comb begin
        logic [LEN_W-1:0]     pidx;
        logic [PAT_IDX_W-1:0] psel;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            pidx        = len_eff - LEN_W'(k) - LEN_W'(1);
            psel        = pidx[PAT_IDX_W-1:0];
            cell_use[k] = LEN_W'(k) < len_eff;
            cell_pat[k] = fold_case(pat_all[psel*BYTE_W +: BYTE_W]);
        end
    end

    assign s_tready = !m_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign in_lim   = pos_reg < limit_reg;

    assign byte_chain[0] = fold_case(s_tdata[BYTE_W-1:0]);
    assign valid_chain[0] = 1'b1;

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        cps_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (s_acc && in_lim),
            .clear     (s_acc && s_tlast),
            .byte_in   (byte_chain[g]),
            .valid_in  (valid_chain[g]),
            .pat_byte  (cell_pat[g]),
            .pat_use   (cell_use[g]),
            .byte_out  (byte_chain[g+1]),
            .valid_out (valid_chain[g+1]),
            .hit       (cell_hit[g])
        );
    end

    assign found_now = seen_reg || (len_eff == '0) ||
                       (in_lim && (len_eff != '0) && (&cell_hit));

    always_comb begin
        pos_next     = pos_reg;
        seen_next    = seen_reg;
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_acc) begin
            m_valid_next = 1'b1;
            if (s_tlast) begin
                pos_next  = '0;
                seen_next = 1'b0;
            end else begin
                seen_next = found_now;
                if (pos_reg != POS_MAX) begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            seen_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            found_reg <= found_now;
            last_reg  <= s_tlast;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, found_reg};
    assign m_tlast  = last_reg;

    // window fill is always a contiguous run starting at the newest cell
    `CPS_ASSERT_IMP(a_fill_contig, aclk, aresetn, 1'b1,
        ((valid_chain & (valid_chain + 1'b1)) == '0), "window valid bits not contiguous")
    `CPS_ASSERT_NXT(a_empty_pat, aclk, aresetn, s_acc && (len_eff == '0),
        found_reg, "empty pattern not reported as found")
    `CPS_ASSERT_NXT(a_last_clears, aclk, aresetn, s_acc && s_tlast,
        (pos_reg == '0) && !seen_reg && (valid_chain[MAX_PATTERN:1] == '0),
        "buffer state not cleared after last word")
    `CPS_ASSERT_NXT(a_sticky, aclk, aresetn, s_acc && !s_tlast && seen_reg,
        seen_reg && found_reg, "found flag dropped inside a buffer")

endmodule

// File: test/tb_top.sv
// Self-checking bench for caseless_prefix_substring_search_top: drives byte words
// with random stalls and checks found/buffer_done against a cycle-free predictor.
// Depends on cps_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb_top;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          PHASES         = 10;
    localparam int          PHASE_BYTES    = 110;
    localparam logic [7:0]  LOWER_A        = 8'h61;
    localparam logic [7:0]  LOWER_Z        = 8'h7A;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drain;   // marker: hold the input until all results are back
    } stim_t;

    typedef struct packed {
        logic found;
        logic done;
    } verdict_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [cps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [cps_pkg::CFG_W-1:0]     cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;     // [7:0] data_byte
    logic        s_tlast   = 1'b0;   // last_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;            // [0] found, [7:1] zero
    logic        m_tlast;            // buffer_done

    caseless_prefix_substring_search_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // search predictor: configuration copy and per-buffer state
    logic [63:0] pat_low      = '0;
    logic [63:0] pat_high     = '0;
    logic [4:0]  pat_len      = '0;
    logic [31:0] look_limit   = '0;
    logic [7:0]  window [16]  = '{default: 8'h00};
    logic [31:0] position     = '0;
    logic        seen         = 1'b0;

    // stimulus side
    stim_t       stim_q [$];
    verdict_t    pending_verdicts [$];
    stim_t       next_word;
    verdict_t    want;
    logic [7:0]  pick_pat [16];
    int unsigned pick_len;
    bit          calm;
    bit          have_byte;
    bit          byte_taken;
    bit          drain_wait;
    bit          any_move;
    int unsigned send_gap;
    int unsigned sink_gap;
    int unsigned idle_cycles;
    int unsigned mismatch_count;
    int unsigned bytes_sent;
    int unsigned buffers_closed;
    int unsigned buffers_matched;
    int unsigned settings_count;

    function automatic logic [7:0] fold_letter(input logic [7:0] c);
        if (c >= cps_pkg::CHAR_UPPER_A && c <= cps_pkg::CHAR_UPPER_Z) begin
            return c | 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] pattern_char(input int unsigned k);
        if (k < 8) begin
            return fold_letter(pat_low[8*k +: 8]);
        end
        return fold_letter(pat_high[8*(k-8) +: 8]);
    endfunction

    function automatic void load_reg(input logic [cps_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [63:0] val);
        case (idx)
            cps_pkg::REG_PAT_LOW:  pat_low    = val;
            cps_pkg::REG_PAT_HIGH: pat_high   = val;
            cps_pkg::REG_PAT_LEN:  pat_len    = val[4:0];
            cps_pkg::REG_LIMIT:    look_limit = val[31:0];
            default: ;
        endcase
    endfunction

    function automatic verdict_t scan_byte(input logic [7:0] b, input logic last);
        verdict_t    v;
        int unsigned n;
        int          k;
        logic        hit;
        n = (pat_len > 16) ? 16 : pat_len;
        if (n == 0) begin
            seen = 1'b1;
        end
        if (position < look_limit) begin
            for (k = 15; k > 0; k--) begin
                window[k] = window[k-1];
            end
            window[0] = fold_letter(b);
            position++;
            if (n > 0 && position >= n) begin
                hit = 1'b1;
                for (k = 0; k < n; k++) begin
                    if (window[k] != pattern_char(n - 1 - k)) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    seen = 1'b1;
                end
            end
        end else if (position != cps_pkg::POS_MAX) begin
            position++;
        end
        v.found = seen;
        v.done  = last;
        if (last) begin
            window   = '{default: 8'h00};
            position = '0;
            seen     = 1'b0;
        end
        return v;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= cps_pkg::CHAR_UPPER_A && c <= cps_pkg::CHAR_UPPER_Z) ||
               (c >= LOWER_A && c <= LOWER_Z);
    endfunction

    function automatic logic [7:0] mix_case(input logic [7:0] c);
        if (is_letter(c) && $urandom_range(0, 1) == 1) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    // mostly near-miss bytes drawn from the pattern, some fully random
    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 9) < 6) begin
            return mix_case(pick_pat[$urandom_range(0, 15)]);
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // driver: input words and result-side ready, changed on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (byte_taken) begin
                have_byte  = 1'b0;
                byte_taken = 1'b0;
                send_gap   = pick_gap();
            end
            if (!have_byte) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (drain_wait) begin
                    if (pending_verdicts.size() == 0) begin
                        drain_wait = 1'b0;
                    end
                end else if (stim_q.size() > 0) begin
                    next_word = stim_q.pop_front();
                    if (next_word.drain) begin
                        drain_wait = 1'b1;
                    end else begin
                        have_byte = 1'b1;
                        s_tdata <= next_word.data;
                        s_tlast <= next_word.last;
                    end
                end
            end
            s_tvalid <= have_byte;
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                sink_gap = pick_gap();
            end
        end
    end

    // monitor: all handshakes sampled on the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            any_move = 1'b0;
            if (cfg_valid && cfg_ready) begin
                load_reg(cfg_index, cfg_data);
                any_move = 1'b1;
            end
            if (s_tvalid && s_tready) begin
                pending_verdicts.push_back(scan_byte(s_tdata, s_tlast));
                byte_taken = 1'b1;
                bytes_sent++;
                any_move   = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                any_move = 1'b1;
                if (pending_verdicts.size() == 0) begin
                    $error("result word with no expectation pending");
                    mismatch_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_tdata[0] !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, m_tdata[0]);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.done) begin
                        $error("buffer_done: expected %0d, got %0d", want.done, m_tlast);
                        mismatch_count++;
                    end
                    if (m_tdata[7:1] !== 7'd0) begin
                        $error("m_tdata pad: expected 0, got %0h", m_tdata[7:1]);
                        mismatch_count++;
                    end
                    if (want.done) begin
                        buffers_closed++;
                        if (want.found) begin
                            buffers_matched++;
                        end
                    end
                end
            end
            idle_cycles = any_move ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [cps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
    endtask

    // pack pick_pat into the two pattern words and write all four registers
    task automatic apply_setting(input int unsigned len, input logic [31:0] lim);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] len_word;
        int          k;
        for (k = 0; k < 8; k++) begin
            lo[8*k +: 8] = pick_pat[k];
            hi[8*k +: 8] = pick_pat[k + 8];
        end
        len_word      = {$urandom, $urandom};
        len_word[4:0] = len[4:0];
        pick_len      = len;
        write_reg(cps_pkg::REG_PAT_LOW, lo);
        write_reg(cps_pkg::REG_PAT_HIGH, hi);
        write_reg(cps_pkg::REG_PAT_LEN, len_word);
        write_reg(cps_pkg::REG_LIMIT, {$urandom, lim});
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        stim_q.push_back('{data: b, last: last, drain: 1'b0});
    endtask

    // one buffer; may carry the pattern in random case, sometimes with one byte spoiled
    task automatic queue_buffer(input int unsigned blen, input bit plant);
        int unsigned n;
        int unsigned plant_at;
        int          spoil_at;
        int unsigned k;
        logic [7:0]  b;
        n        = (pick_len > 16) ? 16 : pick_len;
        plant    = plant && n > 0 && blen >= n;
        plant_at = plant ? $urandom_range(0, blen - n) : 0;
        spoil_at = (plant && $urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
        for (k = 0; k < blen; k++) begin
            if (plant && k >= plant_at && k < plant_at + n && int'(k - plant_at) != spoil_at)
            begin
                b = mix_case(pick_pat[k - plant_at]);
            end else begin
                b = noise_byte();
            end
            push_byte(b, k == blen - 1);
        end
    endtask

    task automatic wait_idle();
        while (stim_q.size() != 0 || have_byte || drain_wait || pending_verdicts.size() != 0)
        begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    initial begin : main_seq
        int          phase;
        int          k;
        int unsigned n;
        int unsigned len;
        int unsigned blen;
        int unsigned r;
        int unsigned phase_bytes;
        logic [31:0] lim;
        bit          paused_once;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // mixed-case hit of "aBc", then bytes around the letter range
        pick_pat = '{default: 8'hFF};
        pick_pat[0] = 8'h61;
        pick_pat[1] = 8'h42;
        pick_pat[2] = 8'h63;
        apply_setting(3, 32'd8);
        push_byte(8'h78, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h62, 1'b0);
        push_byte(8'h43, 1'b0);
        push_byte(8'h7A, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h40, 1'b0);
        push_byte(8'h5B, 1'b0);
        push_byte(8'hFF, 1'b1);
        wait_idle();

        // empty pattern matches at once, even with a zero limit
        pick_pat = '{default: 8'h00};
        apply_setting(0, 32'd0);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b1);
        wait_idle();

        // overlong length clamps to 16; pattern holds zero, 'A', 'Z' and non-letters
        pick_pat = '{8'h41, 8'h7A, 8'h00, 8'h51, 8'h6D, 8'h5A, 8'hFF, 8'h78,
                     8'h61, 8'h40, 8'h5B, 8'h6B, 8'h60, 8'h7B, 8'h7F, 8'h80};
        apply_setting(31, 32'hFFFF_FFFF);
        for (k = 0; k < 16; k++) begin
            push_byte(is_letter(pick_pat[k]) ? pick_pat[k] ^ 8'h20 : pick_pat[k], k == 15);
        end
        wait_idle();

        paused_once = 1'b0;
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: len = 0;
                1: len = 16;
                2: len = 31;
                3: len = 1;
                default: len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                           : $urandom_range(1, 6);
            endcase
            n = (len > 16) ? 16 : len;
            for (k = 0; k < 16; k++) begin
                if (k < n && $urandom_range(0, 4) != 0) begin
                    pick_pat[k] = mix_case(LOWER_A + 8'($urandom_range(0, 3)));
                end else begin
                    pick_pat[k] = 8'($urandom_range(0, 255));
                end
            end
            case (phase % 4)
                0: lim = 32'hFFFF_FFFF;
                1: lim = $urandom_range(0, 40);
                2: lim = $urandom;
                default: lim = (phase == 3) ? 32'd0 : $urandom_range(n, n + 20);
            endcase
            calm = (phase == 5 || phase == 8);
            apply_setting(len, lim);

            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                if ((phase == 2 && phase_bytes >= 60 && !paused_once) ||
                    $urandom_range(0, 49) == 0) begin
                    stim_q.push_back('{data: 8'h00, last: 1'b0, drain: 1'b1});
                    paused_once = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    blen = $urandom_range(1, 12);
                end else if (r < 95) begin
                    blen = $urandom_range(13, 40);
                end else begin
                    blen = $urandom_range(41, 80);
                end
                queue_buffer(blen, $urandom_range(0, 9) < 6);
                phase_bytes += blen;
            end
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        $display("Scanned %0d bytes in %0d buffers under %0d register settings; %0d matched.",
                 bytes_sent, buffers_closed, settings_count, buffers_matched);
        $display("Included empty, clamped and limit-clipped patterns with stalls on both sides.");
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
